### hdl/hbp_pkg.sv
`timescale 1ns / 1ps

package hbp_pkg;

  localparam logic [7:0] PAD_MARK    = 8'h80;
  localparam logic [3:0] LENGTH_WORD = 4'd14;
  localparam logic [3:0] PRE_LENGTH  = 4'd13;
  localparam logic [3:0] LAST_WORD   = 4'd15;
  localparam logic [1:0] LAST_SLOT   = 2'd3;

  // word emission commands from controller to datapath
  localparam logic [2:0] EMIT_NONE   = 3'd0;
  localparam logic [2:0] EMIT_MARK   = 3'd1;
  localparam logic [2:0] EMIT_ZERO   = 3'd2;
  localparam logic [2:0] EMIT_LEN_LO = 3'd3;
  localparam logic [2:0] EMIT_LEN_HI = 3'd4;

  typedef struct packed {
    logic       append;
    logic [2:0] emit;
  } hbp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic at_pre_length;
  } hbp_status_t;

endpackage

### hdl/hbp_datapath.sv
`timescale 1ns / 1ps

module hbp_datapath
  import hbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic [7:0]  data_byte,
  input  hbp_cmd_t    cmd,
  output hbp_status_t status,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [31:0] block_word,
  output logic [3:0]  word_index,
  output logic        block_end,
  output logic        last
);

  logic        big_endian;
  logic [31:0] partial_word;
  logic [31:0] partial_word_next;
  logic [1:0]  byte_slot;
  logic [1:0]  byte_slot_next;
  logic [3:0]  word_count;
  logic [3:0]  word_count_next;
  logic [31:0] byte_total;
  logic [31:0] byte_total_next;
  logic        out_valid_next;
  logic        load;
  logic [31:0] load_word;
  logic        load_last;
  logic [31:0] bit_length;

  // places a byte in its lane of the word for the current slot
  function automatic logic [31:0] lane_place(logic [7:0] b, logic [1:0] slot, logic big);
    logic [1:0] pos;
    pos = big ? slot : (LAST_SLOT - slot);
    unique case (pos)
      2'd0: lane_place = {b, 24'd0};
      2'd1: lane_place = {8'd0, b, 16'd0};
      2'd2: lane_place = {16'd0, b, 8'd0};
      default: lane_place = {24'd0, b};
    endcase
  endfunction

  assign bit_length           = {byte_total[28:0], 3'b000};
  assign status.out_free      = !out_valid || out_ready;
  assign status.at_pre_length = (word_count == PRE_LENGTH);

  always_comb begin
    partial_word_next = partial_word;
    byte_slot_next    = byte_slot;
    word_count_next   = word_count;
    byte_total_next   = byte_total;
    load              = 1'b0;
    load_word         = 32'd0;
    load_last         = 1'b0;
    if (cmd.append) begin
      byte_total_next   = byte_total + 32'd1;
      partial_word_next = partial_word | lane_place(data_byte, byte_slot, big_endian);
      byte_slot_next    = byte_slot + 2'd1;
      if (byte_slot == LAST_SLOT) begin
        load              = 1'b1;
        load_word         = partial_word_next;
        load_last         = 1'b1;
        partial_word_next = 32'd0;
        word_count_next   = word_count + 4'd1;
      end
    end else begin
      unique case (cmd.emit)
        EMIT_MARK: begin
          load              = 1'b1;
          load_word         = partial_word | lane_place(PAD_MARK, byte_slot, big_endian);
          partial_word_next = 32'd0;
          byte_slot_next    = 2'd0;
          word_count_next   = word_count + 4'd1;
        end
        EMIT_ZERO: begin
          load            = 1'b1;
          word_count_next = word_count + 4'd1;
        end
        EMIT_LEN_LO: begin
          load            = 1'b1;
          load_word       = big_endian ? 32'd0 : bit_length;
          word_count_next = word_count + 4'd1;
        end
        EMIT_LEN_HI: begin
          load              = 1'b1;
          load_word         = big_endian ? bit_length : 32'd0;
          load_last         = 1'b1;
          partial_word_next = 32'd0;
          byte_slot_next    = 2'd0;
          word_count_next   = 4'd0;
          byte_total_next   = 32'd0;
        end
        default: begin
          load = 1'b0;
        end
      endcase
    end
    out_valid_next = load ? 1'b1 : (out_valid && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      big_endian   <= 1'b1;
      partial_word <= 32'd0;
      byte_slot    <= 2'd0;
      word_count   <= 4'd0;
      byte_total   <= 32'd0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        big_endian <= cfg_wr_data;
      end
      partial_word <= partial_word_next;
      byte_slot    <= byte_slot_next;
      word_count   <= word_count_next;
      byte_total   <= byte_total_next;
      out_valid    <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      block_word <= load_word;
      word_index <= word_count;
      block_end  <= (word_count == LAST_WORD);
      last       <= load_last;
    end
  end

`ifndef SYNTHESIS
  a_block_end_matches_index: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (block_end == (word_index == LAST_WORD)))
    else $error("block_end disagrees with word_index");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.append || cmd.emit != EMIT_NONE) |-> status.out_free)
    else $error("word loaded while output register still full");

  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit == EMIT_LEN_HI && !cmd.append) |=>
      (word_count == 4'd0 && byte_slot == 2'd0 && byte_total == 32'd0 && last))
    else $error("counters not cleared after length word");
`endif

endmodule

### hdl/hbp_controller.sv
`timescale 1ns / 1ps

module hbp_controller
  import hbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  hbp_status_t status,
  output hbp_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MARK   = 3'd1;
  localparam logic [2:0] ST_FILL   = 3'd2;
  localparam logic [2:0] ST_LEN_LO = 3'd3;
  localparam logic [2:0] ST_LEN_HI = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;

  assign in_ready = (state == ST_IDLE) && status.out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd.append = 1'b0;
    cmd.emit   = EMIT_NONE;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req_type) begin
            state_next = ST_MARK;
          end else begin
            cmd.append = 1'b1;
          end
        end
      end
      ST_MARK: begin
        if (status.out_free) begin
          cmd.emit   = EMIT_MARK;
          state_next = status.at_pre_length ? ST_LEN_LO : ST_FILL;
        end
      end
      ST_FILL: begin
        // zero words until the length words are due
        if (status.out_free) begin
          cmd.emit = EMIT_ZERO;
          if (status.at_pre_length) begin
            state_next = ST_LEN_LO;
          end
        end
      end
      ST_LEN_LO: begin
        if (status.out_free) begin
          cmd.emit   = EMIT_LEN_LO;
          state_next = ST_LEN_HI;
        end
      end
      ST_LEN_HI: begin
        if (status.out_free) begin
          cmd.emit   = EMIT_LEN_HI;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_finish_enters_padding: assert property (@(posedge clk) disable iff (rst)
    (accept && req_type) |=> (state == ST_MARK && !in_ready))
    else $error("finish word did not start padding");
`endif

endmodule

### hdl/hash_block_padder.sv
`timescale 1ns / 1ps
// message word: registered, on the output in the cycle after the byte that completes it
// throughput: one byte per cycle while the output register drains each cycle
// finish: once accepted, 3 to 18 words follow one per cycle while the output drains,
// issued by the padding sequencer; no input is taken meanwhile
// reset: synchronous, clears counters, length and output valid; big_endian returns to 1

module hash_block_padder
  import hbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] block_word,
  output logic [3:0]  word_index,
  output logic        block_end,
  output logic        last
);

  hbp_cmd_t    cmd;
  hbp_status_t status;

  hbp_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .req_type (req_type),
    .status   (status),
    .cmd      (cmd)
  );

  hbp_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .data_byte   (data_byte),
    .cmd         (cmd),
    .status      (status),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .block_word  (block_word),
    .word_index  (word_index),
    .block_end   (block_end),
    .last        (last)
  );

endmodule
